### sv/mvc_pkg.sv
// Shared types and constants for the motion vector clip unit.
// Used by mvc_cfg, mvc_bounds, mvc_clip and motion_vector_clip_unit_core.
package mvc_pkg;

  localparam int MVC_FRAC_BITS_DEF = 4;
  localparam int MVC_MARGIN        = 8;
  // signed width of an unscaled bound, enough for every field combination
  localparam int MVC_UNSC_W        = 17;
  localparam int MVC_MV_W          = 18;
  localparam int MVC_MV_HI         = 131071;
  localparam int MVC_MV_LO         = -131072;
  localparam int MVC_ADDR_W        = 4;
  localparam int MVC_DATA_W        = 32;

  localparam logic [13:0] MVC_PIC_W_RST = 14'd1920;
  localparam logic [13:0] MVC_PIC_H_RST = 14'd1080;
  localparam logic [7:0]  MVC_LCU_RST   = 8'd128;
  localparam logic [13:0] MVC_WOFF_RST  = 14'd0;

  typedef enum logic [1:0] {
    REG_PIC_W = 2'd0,
    REG_PIC_H = 2'd1,
    REG_LCU   = 2'd2,
    REG_WOFF  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CLIP_BOTH   = 2'd0,
    OP_CLIP_HOR    = 2'd1,
    OP_CLIP_SUBPIC = 2'd2,
    OP_CLIP_WRAP   = 2'd3
  } op_t;

  typedef struct packed {
    logic [13:0] pic_w;
    logic [13:0] pic_h;
    logic [7:0]  lcu;
    logic [13:0] wrap_offset;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [12:0]         block_x;
    logic [12:0]         block_y;
    logic [7:0]          block_width;
    logic signed [17:0]  mv_hor;
    logic signed [17:0]  mv_ver;
    logic                sub_applies;
    logic [12:0]         sub_left;
    logic [12:0]         sub_right;
    logic [12:0]         sub_top;
    logic [12:0]         sub_bottom;
  } item_t;

endpackage

### sv/mvc_cfg.sv
// Configuration register file with APB-style access.
// Depends on mvc_pkg for the register map and reset values.
module mvc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvc_pkg::MVC_ADDR_W-1:0]  paddr,
  input  logic [mvc_pkg::MVC_DATA_W-1:0]  pwdata,
  output logic [mvc_pkg::MVC_DATA_W-1:0]  prdata,
  output mvc_pkg::cfg_t                   cfg
);
  import mvc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PIC_W: cfg_nxt.pic_w       = pwdata[13:0];
        REG_PIC_H: cfg_nxt.pic_h       = pwdata[13:0];
        REG_LCU:   cfg_nxt.lcu         = pwdata[7:0];
        REG_WOFF:  cfg_nxt.wrap_offset = pwdata[13:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pic_w       <= MVC_PIC_W_RST;
      cfg_r.pic_h       <= MVC_PIC_H_RST;
      cfg_r.lcu         <= MVC_LCU_RST;
      cfg_r.wrap_offset <= MVC_WOFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_PIC_W: prdata = MVC_DATA_W'(cfg_r.pic_w);
      REG_PIC_H: prdata = MVC_DATA_W'(cfg_r.pic_h);
      REG_LCU:   prdata = MVC_DATA_W'(cfg_r.lcu);
      REG_WOFF:  prdata = MVC_DATA_W'(cfg_r.wrap_offset);
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### sv/mvc_bounds.sv
// Bound stage: forms the scaled clip window for one registered transaction.
// Depends on mvc_pkg for item and configuration types.
module mvc_bounds #(
  parameter int  FRAC_BITS = mvc_pkg::MVC_FRAC_BITS_DEF,
  localparam int BND_W     = 19 + FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  item_vld,
  input  mvc_pkg::item_t                        item,
  input  mvc_pkg::cfg_t                         cfg,
  output logic                                  bnd_vld,
  output mvc_pkg::op_t                          bnd_op,
  output logic signed [BND_W-1:0]               hmin,
  output logic signed [BND_W-1:0]               hmax,
  output logic signed [BND_W-1:0]               vmin,
  output logic signed [BND_W-1:0]               vmax,
  output logic signed [BND_W-1:0]               woff,
  output logic signed [mvc_pkg::MVC_MV_W-1:0]   mv_hor,
  output logic signed [mvc_pkg::MVC_MV_W-1:0]   mv_ver
);
  import mvc_pkg::*;

  localparam int UW = MVC_UNSC_W;
  localparam logic signed [UW-1:0] MARGIN_M1 = UW'(MVC_MARGIN - 1);
  localparam logic signed [UW-1:0] ONE       = UW'(1);

  logic signed [UW-1:0] bx, by, bw, pw, ph, lcu, sl, sr, st, sb;
  logic signed [UW-1:0] hmax_u, hmin_u, vmax_u, vmin_u;
  logic                 use_sub;

  logic                   vld_r;
  op_t                    op_r;
  logic signed [BND_W-1:0] hmin_r, hmax_r, vmin_r, vmax_r, woff_r;
  logic signed [BND_W-1:0] hmin_nxt, hmax_nxt, vmin_nxt, vmax_nxt, woff_nxt;
  logic signed [MVC_MV_W-1:0] mv_hor_r, mv_ver_r;

  assign bx  = signed'(UW'(item.block_x));
  assign by  = signed'(UW'(item.block_y));
  assign bw  = signed'(UW'(item.block_width));
  assign sl  = signed'(UW'(item.sub_left));
  assign sr  = signed'(UW'(item.sub_right));
  assign st  = signed'(UW'(item.sub_top));
  assign sb  = signed'(UW'(item.sub_bottom));
  assign pw  = signed'(UW'(cfg.pic_w));
  assign ph  = signed'(UW'(cfg.pic_h));
  assign lcu = signed'(UW'(cfg.lcu));

  assign use_sub = (item.op == OP_CLIP_SUBPIC) && item.sub_applies;

  always_comb begin
    hmin_u = -lcu - MARGIN_M1 - bx;
    vmin_u = -lcu - MARGIN_M1 - by;
    hmax_u = pw + MARGIN_M1 - bx;
    vmax_u = ph + MARGIN_M1 - by;
    if (use_sub) begin
      // right/bottom are inclusive: (r + 1) + margin - pos - 1
      hmax_u = sr + MARGIN_M1 + ONE - bx;
      vmax_u = sb + MARGIN_M1 + ONE - by;
      hmin_u = -lcu - MARGIN_M1 - bx + sl;
      vmin_u = -lcu - MARGIN_M1 - by + st;
    end else if (item.op == OP_CLIP_WRAP) begin
      hmax_u = pw + lcu - bw + MARGIN_M1 - bx;
    end
  end

  always_comb begin
    hmin_nxt = BND_W'(hmin_u) <<< FRAC_BITS;
    hmax_nxt = BND_W'(hmax_u) <<< FRAC_BITS;
    vmin_nxt = BND_W'(vmin_u) <<< FRAC_BITS;
    vmax_nxt = BND_W'(vmax_u) <<< FRAC_BITS;
    woff_nxt = BND_W'(signed'({1'b0, cfg.wrap_offset})) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= item.op;
    hmin_r   <= hmin_nxt;
    hmax_r   <= hmax_nxt;
    vmin_r   <= vmin_nxt;
    vmax_r   <= vmax_nxt;
    woff_r   <= woff_nxt;
    mv_hor_r <= item.mv_hor;
    mv_ver_r <= item.mv_ver;
  end

  assign bnd_vld = vld_r;
  assign bnd_op  = op_r;
  assign hmin    = hmin_r;
  assign hmax    = hmax_r;
  assign vmin    = vmin_r;
  assign vmax    = vmax_r;
  assign woff    = woff_r;
  assign mv_hor  = mv_hor_r;
  assign mv_ver  = mv_ver_r;

endmodule

### sv/mvc_clip.sv
// Clip stage: clamps the horizontal component and, except for OP_CLIP_HOR, the vertical one,
// applies wrap-around, saturates, registers result. Depends on mvc_pkg for op codes and vector limits.
module mvc_clip #(
  parameter int  FRAC_BITS = mvc_pkg::MVC_FRAC_BITS_DEF,
  localparam int BND_W     = 19 + FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  bnd_vld,
  input  mvc_pkg::op_t                          bnd_op,
  input  logic signed [BND_W-1:0]               hmin,
  input  logic signed [BND_W-1:0]               hmax,
  input  logic signed [BND_W-1:0]               vmin,
  input  logic signed [BND_W-1:0]               vmax,
  input  logic signed [BND_W-1:0]               woff,
  input  logic signed [mvc_pkg::MVC_MV_W-1:0]   mv_hor,
  input  logic signed [mvc_pkg::MVC_MV_W-1:0]   mv_ver,
  output logic                                  res_vld,
  output logic signed [mvc_pkg::MVC_MV_W-1:0]   res_hor,
  output logic signed [mvc_pkg::MVC_MV_W-1:0]   res_ver,
  output logic                                  res_no_wrap
);
  import mvc_pkg::*;

  localparam logic signed [BND_W-1:0] SAT_HI = BND_W'(MVC_MV_HI);
  localparam logic signed [BND_W-1:0] SAT_LO = BND_W'(MVC_MV_LO);

  // crossed bounds resolve to hi since hi is applied last
  function automatic logic signed [BND_W-1:0] clamp(
    input logic signed [BND_W-1:0] lo,
    input logic signed [BND_W-1:0] hi,
    input logic signed [BND_W-1:0] v
  );
    logic signed [BND_W-1:0] t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

  function automatic logic signed [MVC_MV_W-1:0] sat(input logic signed [BND_W-1:0] v);
    logic signed [BND_W-1:0] t;
    t = v;
    if (t > SAT_HI) t = SAT_HI;
    if (t < SAT_LO) t = SAT_LO;
    return t[MVC_MV_W-1:0];
  endfunction

  logic signed [BND_W-1:0] hor, ver, oh, ov;
  logic                    nw;

  logic                       vld_r;
  logic signed [MVC_MV_W-1:0] hor_r, ver_r, hor_nxt, ver_nxt;
  logic                       nw_r;

  assign hor = BND_W'(mv_hor);
  assign ver = BND_W'(mv_ver);

  always_comb begin
    oh = clamp(hmin, hmax, hor);
    ov = clamp(vmin, vmax, ver);
    nw = 1'b1;
    unique case (bnd_op)
      OP_CLIP_WRAP: begin
        oh = hor;
        if (hor > hmax) begin
          oh = clamp(hmin, hmax, hor - woff);
          nw = 1'b0;
        end
        if (oh < hmin) begin
          oh = clamp(hmin, hmax, oh + woff);
          nw = 1'b0;
        end
      end
      OP_CLIP_HOR:    ov = ver;
      OP_CLIP_BOTH,
      OP_CLIP_SUBPIC: ;
      default:        ;
    endcase
    hor_nxt = sat(oh);
    ver_nxt = sat(ov);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= bnd_vld;
    end
  end

  always_ff @(posedge clk) begin
    hor_r <= hor_nxt;
    ver_r <= ver_nxt;
    nw_r  <= nw;
  end

  assign res_vld     = vld_r;
  assign res_hor     = hor_r;
  assign res_ver     = ver_r;
  assign res_no_wrap = nw_r;

endmodule

### sv/motion_vector_clip_unit_core.sv
// Top level of the motion vector clip unit: input register, bound stage, clip stage.
// Depends on mvc_pkg, mvc_cfg, mvc_bounds and mvc_clip.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------------------
//   input    | start, busy (accept: start&!busy) | in_op .. in_sub_bottom
//   result   | out_valid strobe, one cycle   | out_mv_out_hor, out_mv_out_ver, out_no_wrap
//   config   | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// One transaction per cycle; busy is never raised.
// A transaction passes the input register, bound register and result register in that order.
// Synchronous active-low reset clears the valid pipeline and loads register defaults.
// Results appear on out_valid for one cycle and are not held for the receiver.
module motion_vector_clip_unit_core #(
  parameter int FRAC_BITS = mvc_pkg::MVC_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_op,
  input  logic [12:0]                           in_block_x,
  input  logic [12:0]                           in_block_y,
  input  logic [7:0]                            in_block_width,
  input  logic signed [mvc_pkg::MVC_MV_W-1:0]   in_mv_in_hor,
  input  logic signed [mvc_pkg::MVC_MV_W-1:0]   in_mv_in_ver,
  input  logic                                  in_subpic_applies,
  input  logic [12:0]                           in_sub_left,
  input  logic [12:0]                           in_sub_right,
  input  logic [12:0]                           in_sub_top,
  input  logic [12:0]                           in_sub_bottom,
  output logic                                  out_valid,
  output logic signed [mvc_pkg::MVC_MV_W-1:0]   out_mv_out_hor,
  output logic signed [mvc_pkg::MVC_MV_W-1:0]   out_mv_out_ver,
  output logic                                  out_no_wrap,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mvc_pkg::MVC_ADDR_W-1:0]        paddr,
  input  logic [mvc_pkg::MVC_DATA_W-1:0]        pwdata,
  output logic [mvc_pkg::MVC_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import mvc_pkg::*;

  localparam int BND_W = 19 + FRAC_BITS;

  cfg_t  cfg;
  item_t item_r;
  item_t item_nxt;
  logic  item_vld_r;
  logic  accept;

  logic                    bnd_vld;
  op_t                     bnd_op;
  logic signed [BND_W-1:0] hmin, hmax, vmin, vmax, woff;
  logic signed [MVC_MV_W-1:0] bnd_hor, bnd_ver;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;

  always_comb begin
    item_nxt.op          = op_t'(in_op);
    item_nxt.block_x     = in_block_x;
    item_nxt.block_y     = in_block_y;
    item_nxt.block_width = in_block_width;
    item_nxt.mv_hor      = in_mv_in_hor;
    item_nxt.mv_ver      = in_mv_in_ver;
    item_nxt.sub_applies = in_subpic_applies;
    item_nxt.sub_left    = in_sub_left;
    item_nxt.sub_right   = in_sub_right;
    item_nxt.sub_top     = in_sub_top;
    item_nxt.sub_bottom  = in_sub_bottom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  mvc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mvc_bounds #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bounds (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .item     (item_r),
    .cfg      (cfg),
    .bnd_vld  (bnd_vld),
    .bnd_op   (bnd_op),
    .hmin     (hmin),
    .hmax     (hmax),
    .vmin     (vmin),
    .vmax     (vmax),
    .woff     (woff),
    .mv_hor   (bnd_hor),
    .mv_ver   (bnd_ver)
  );

  mvc_clip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .bnd_vld     (bnd_vld),
    .bnd_op      (bnd_op),
    .hmin        (hmin),
    .hmax        (hmax),
    .vmin        (vmin),
    .vmax        (vmax),
    .woff        (woff),
    .mv_hor      (bnd_hor),
    .mv_ver      (bnd_ver),
    .res_vld     (out_valid),
    .res_hor     (out_mv_out_hor),
    .res_ver     (out_mv_out_ver),
    .res_no_wrap (out_no_wrap)
  );

endmodule

### verif/tb_motion_vector_clip_unit_core.sv
// Self-checking testbench for motion_vector_clip_unit_core: random and directed clip
// transactions, APB register writes between phases. Depends on mvc_pkg and the core RTL.
module tb_motion_vector_clip_unit_core;
  import mvc_pkg::*;

  localparam longint MV_SCALE = longint'(1) << MVC_FRAC_BITS_DEF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 135;

  typedef struct {
    logic signed [MVC_MV_W-1:0] hor;
    logic signed [MVC_MV_W-1:0] ver;
    logic                       no_wrap;
  } clip_result_t;

  // Tracks register contents, computes the clipped vector per accepted transaction
  // and compares results in order.
  class clip_scoreboard;
    cfg_t         regs;
    clip_result_t pending_q[$];
    int           errors;

    function new();
      regs.pic_w       = MVC_PIC_W_RST;
      regs.pic_h       = MVC_PIC_H_RST;
      regs.lcu         = MVC_LCU_RST;
      regs.wrap_offset = MVC_WOFF_RST;
      errors           = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_PIC_W: regs.pic_w       = value[13:0];
        REG_PIC_H: regs.pic_h       = value[13:0];
        REG_LCU:   regs.lcu         = value[7:0];
        REG_WOFF:  regs.wrap_offset = value[13:0];
        default: ;
      endcase
    endfunction

    function longint fit_range(longint lo, longint hi, longint v);
      longint t;
      t = (v < lo) ? lo : v;
      return (t > hi) ? hi : t;
    endfunction

    function logic signed [MVC_MV_W-1:0] saturate(longint v);
      longint t;
      t = (v > MVC_MV_HI) ? MVC_MV_HI : v;
      t = (t < MVC_MV_LO) ? MVC_MV_LO : t;
      return t[MVC_MV_W-1:0];
    endfunction

    // scaled clip window for one transaction
    function void clip_window(item_t it, output longint hmax, output longint hmin,
                              output longint vmax, output longint vmin);
      longint bx, by, bw, lcu, pw, ph;
      bx  = longint'(it.block_x);
      by  = longint'(it.block_y);
      bw  = longint'(it.block_width);
      lcu = longint'(regs.lcu);
      pw  = longint'(regs.pic_w);
      ph  = longint'(regs.pic_h);
      if (it.op == OP_CLIP_SUBPIC && it.sub_applies) begin
        hmax = (longint'(it.sub_right) + 1 + MVC_MARGIN - bx - 1) * MV_SCALE;
        hmin = (-lcu - MVC_MARGIN - (bx - longint'(it.sub_left)) + 1) * MV_SCALE;
        vmax = (longint'(it.sub_bottom) + 1 + MVC_MARGIN - by - 1) * MV_SCALE;
        vmin = (-lcu - MVC_MARGIN - (by - longint'(it.sub_top)) + 1) * MV_SCALE;
      end else begin
        hmax = (pw + MVC_MARGIN - bx - 1) * MV_SCALE;
        hmin = (-lcu - MVC_MARGIN - bx + 1) * MV_SCALE;
        vmax = (ph + MVC_MARGIN - by - 1) * MV_SCALE;
        vmin = (-lcu - MVC_MARGIN - by + 1) * MV_SCALE;
      end
      if (it.op == OP_CLIP_WRAP) hmax = (pw + lcu - bw + MVC_MARGIN - bx - 1) * MV_SCALE;
    endfunction

    function clip_result_t clip_vector(item_t it);
      clip_result_t r;
      longint hmax, hmin, vmax, vmin, h, v, oh, ov, woff;
      clip_window(it, hmax, hmin, vmax, vmin);
      h = longint'(it.mv_hor);
      v = longint'(it.mv_ver);
      r.no_wrap = 1'b1;
      if (it.op == OP_CLIP_WRAP) begin
        woff = longint'(regs.wrap_offset) * MV_SCALE;
        oh = h;
        if (oh > hmax) begin
          oh = fit_range(hmin, hmax, oh - woff);
          r.no_wrap = 1'b0;
        end
        if (oh < hmin) begin
          oh = fit_range(hmin, hmax, oh + woff);
          r.no_wrap = 1'b0;
        end
        ov = fit_range(vmin, vmax, v);
      end else begin
        oh = fit_range(hmin, hmax, h);
        ov = (it.op == OP_CLIP_HOR) ? v : fit_range(vmin, vmax, v);
      end
      r.hor = saturate(oh);
      r.ver = saturate(ov);
      return r;
    endfunction

    function void note_item(item_t it);
      pending_q.push_back(clip_vector(it));
    endfunction

    function void check_result(clip_result_t got);
      clip_result_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result hor %0d ver %0d no_wrap %0b", $time,
                 got.hor, got.ver, got.no_wrap);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.hor !== exp_r.hor) begin
        $display("%0t: mv_out_hor mismatch: expected %0d actual %0d", $time, exp_r.hor,
                 got.hor);
        errors++;
      end
      if (got.ver !== exp_r.ver) begin
        $display("%0t: mv_out_ver mismatch: expected %0d actual %0d", $time, exp_r.ver,
                 got.ver);
        errors++;
      end
      if (got.no_wrap !== exp_r.no_wrap) begin
        $display("%0t: no_wrap mismatch: expected %0b actual %0b", $time, exp_r.no_wrap,
                 got.no_wrap);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [1:0]                  in_op;
  logic [12:0]                 in_block_x;
  logic [12:0]                 in_block_y;
  logic [7:0]                  in_block_width;
  logic signed [MVC_MV_W-1:0]  in_mv_in_hor;
  logic signed [MVC_MV_W-1:0]  in_mv_in_ver;
  logic                        in_subpic_applies;
  logic [12:0]                 in_sub_left;
  logic [12:0]                 in_sub_right;
  logic [12:0]                 in_sub_top;
  logic [12:0]                 in_sub_bottom;
  logic                        out_valid;
  logic signed [MVC_MV_W-1:0]  out_mv_out_hor;
  logic signed [MVC_MV_W-1:0]  out_mv_out_ver;
  logic                        out_no_wrap;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [MVC_ADDR_W-1:0]       paddr;
  logic [MVC_DATA_W-1:0]       pwdata;
  logic [MVC_DATA_W-1:0]       prdata;
  logic                        pready;

  clip_scoreboard sb;

  motion_vector_clip_unit_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_block_x       (in_block_x),
    .in_block_y       (in_block_y),
    .in_block_width   (in_block_width),
    .in_mv_in_hor     (in_mv_in_hor),
    .in_mv_in_ver     (in_mv_in_ver),
    .in_subpic_applies(in_subpic_applies),
    .in_sub_left      (in_sub_left),
    .in_sub_right     (in_sub_right),
    .in_sub_top       (in_sub_top),
    .in_sub_bottom    (in_sub_bottom),
    .out_valid        (out_valid),
    .out_mv_out_hor   (out_mv_out_hor),
    .out_mv_out_ver   (out_mv_out_ver),
    .out_no_wrap      (out_no_wrap),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    clip_result_t got;
    if (rst_n && out_valid) begin
      got.hor     = out_mv_out_hor;
      got.ver     = out_mv_out_ver;
      got.no_wrap = out_no_wrap;
      sb.check_result(got);
    end
  end

  // all tasks are entered right after a rising edge
  // psel stays high on return so that writes can follow back to back
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic write_all(int unsigned pw, int unsigned ph, int unsigned lcu,
                           int unsigned woff);
    write_reg(REG_PIC_W, pw);
    write_reg(REG_PIC_H, ph);
    write_reg(REG_LCU, lcu);
    write_reg(REG_WOFF, woff);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop issuing and let the pipeline empty before touching registers
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_op             <= it.op;
    in_block_x        <= it.block_x;
    in_block_y        <= it.block_y;
    in_block_width    <= it.block_width;
    in_mv_in_hor      <= it.mv_hor;
    in_mv_in_ver      <= it.mv_ver;
    in_subpic_applies <= it.sub_applies;
    in_sub_left       <= it.sub_left;
    in_sub_right      <= it.sub_right;
    in_sub_top        <= it.sub_top;
    in_sub_bottom     <= it.sub_bottom;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  function automatic item_t make_item(op_t op, int bx, int by, int bw, int hor, int ver,
                                      bit sub, int sl, int sr, int st, int sbot);
    item_t it;
    it.op          = op;
    it.block_x     = 13'(bx);
    it.block_y     = 13'(by);
    it.block_width = 8'(bw);
    it.mv_hor      = MVC_MV_W'(hor);
    it.mv_ver      = MVC_MV_W'(ver);
    it.sub_applies = sub;
    it.sub_left    = 13'(sl);
    it.sub_right   = 13'(sr);
    it.sub_top     = 13'(st);
    it.sub_bottom  = 13'(sbot);
    return it;
  endfunction

  function automatic logic signed [MVC_MV_W-1:0] pick_mv(longint lo, longint hi,
                                                          longint woff);
    longint v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 262143);
      1: v = longint'($urandom_range(0, 1024)) - 512;
      2: v = hi + longint'($urandom_range(0, 64)) - 32;
      3: v = lo + longint'($urandom_range(0, 64)) - 32;
      4: v = hi + woff + longint'($urandom_range(0, 64)) - 32;
      default: v = lo - woff + longint'($urandom_range(0, 64)) - 32;
    endcase
    return v[MVC_MV_W-1:0];
  endfunction

  function automatic item_t random_item();
    item_t  it;
    longint hmax, hmin, vmax, vmin, woff;
    int     x_hi, y_hi;
    it.op = op_t'($urandom_range(0, 3));
    it.sub_applies = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      // raw noise across the full field widths
      it.block_x     = 13'($urandom_range(0, 8191));
      it.block_y     = 13'($urandom_range(0, 8191));
      it.block_width = 8'($urandom_range(0, 255));
      it.sub_left    = 13'($urandom_range(0, 8191));
      it.sub_right   = 13'($urandom_range(0, 8191));
      it.sub_top     = 13'($urandom_range(0, 8191));
      it.sub_bottom  = 13'($urandom_range(0, 8191));
    end else begin
      x_hi = (sb.regs.pic_w > 8192) ? 8191 : (sb.regs.pic_w == 0 ? 0 : sb.regs.pic_w - 1);
      y_hi = (sb.regs.pic_h > 8192) ? 8191 : (sb.regs.pic_h == 0 ? 0 : sb.regs.pic_h - 1);
      it.block_x     = 13'($urandom_range(0, x_hi));
      it.block_y     = 13'($urandom_range(0, y_hi));
      it.block_width = 8'($urandom_range(1, 128));
      it.sub_left    = 13'($urandom_range(0, x_hi));
      it.sub_right   = 13'($urandom_range(it.sub_left, x_hi));
      it.sub_top     = 13'($urandom_range(0, y_hi));
      it.sub_bottom  = 13'($urandom_range(it.sub_top, y_hi));
    end
    sb.clip_window(it, hmax, hmin, vmax, vmin);
    woff = longint'(sb.regs.wrap_offset) * MV_SCALE;
    it.mv_hor = pick_mv(hmin, hmax, woff);
    it.mv_ver = pick_mv(vmin, vmax, 0);
    return it;
  endfunction

  function automatic int draw_gap(int gap_mode);
    case (gap_mode)
      0: return $urandom_range(0, 17);
      1: return 0;
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  initial begin
    int unsigned pw, ph, lcu, woff;
    sb                = new();
    rst_n             = 1'b0;
    start             = 1'b0;
    in_op             = '0;
    in_block_x        = '0;
    in_block_y        = '0;
    in_block_width    = '0;
    in_mv_in_hor      = '0;
    in_mv_in_ver      = '0;
    in_subpic_applies = 1'b0;
    in_sub_left       = '0;
    in_sub_right      = '0;
    in_sub_top        = '0;
    in_sub_bottom     = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_item(make_item(OP_CLIP_BOTH, 0, 0, 16, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_BOTH, 0, 0, 16, 131071, -131072, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_HOR, 0, 0, 16, -131072, 131071, 0, 0, 0, 0, 0), 3);
    send_item(make_item(OP_CLIP_SUBPIC, 10, 10, 16, 131071, 131071, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_SUBPIC, 200, 100, 16, 131071, -131072, 1,
                        100, 500, 50, 300), 1);
    // subpicture with left > right and top > bottom: window is crossed
    send_item(make_item(OP_CLIP_SUBPIC, 0, 0, 16, 0, 0, 1, 8191, 0, 8191, 0), 0);
    // wrap with zero offset
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 16, 131071, -131072, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_BOTH, 8191, 8191, 128, 0, 0, 0, 0, 0, 0, 0), 2);
    drain();

    write_all(1920, 1080, 128, 1936);
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 16, 131071, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 16, -131072, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 16, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_WRAP, 1900, 500, 0, 30000, 5000, 0, 0, 0, 0, 0), 4);
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 255, 100000, -5000, 0, 0, 0, 0, 0), 0);
    // just past each edge of the wrap window
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 16, 32625, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 16, -2161, 0, 0, 0, 0, 0, 0), 0);
    drain();

    // smallest picture: crossed windows and low saturation
    write_all(1, 1, 4, 16383);
    send_item(make_item(OP_CLIP_WRAP, 8191, 0, 255, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_BOTH, 8191, 8191, 1, -131072, -131072, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_SUBPIC, 0, 0, 1, 131071, 131071, 1,
                        8191, 8191, 8191, 8191), 0);
    drain();

    write_all(16383, 16383, 255, 16383);
    send_item(make_item(OP_CLIP_WRAP, 0, 0, 1, 131071, 131071, 0, 0, 0, 0, 0), 0);
    send_item(make_item(OP_CLIP_BOTH, 0, 0, 1, -131072, 131071, 0, 0, 0, 0, 0), 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pw = 3840; ph = 2160; lcu = 128; woff = 3904; end
        1: begin pw = 1; ph = 1; lcu = 4; woff = 0; end
        2: begin pw = 8192; ph = 8192; lcu = 128; woff = 16383; end
        3: begin pw = 16383; ph = 16383; lcu = 255; woff = 16383; end
        default: begin
          pw   = $urandom_range(1, 8192);
          ph   = $urandom_range(1, 8192);
          lcu  = 4 << $urandom_range(0, 5);
          woff = $urandom_range(0, 1) ? pw + $urandom_range(0, lcu)
                                      : $urandom_range(0, 16383);
        end
      endcase
      write_all(pw, ph, lcu, woff);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), draw_gap(p % 3));
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### motion_vector_clip_unit_core.f
sv/mvc_pkg.sv
sv/mvc_cfg.sv
sv/mvc_bounds.sv
sv/mvc_clip.sv
sv/motion_vector_clip_unit_core.sv
verif/tb_motion_vector_clip_unit_core.sv
